@@ hdl/lsts_pkg.sv @@
// Shared types and constants of the leap-second table scheduler.
// Used by the table store, the sequencer and the top level.
package lsts_pkg;

    localparam int TABLE_DEPTH_DEF = 10;

    // Item kinds carried in tuser.
    localparam logic [1:0] K_QUERY  = 2'd0;
    localparam logic [1:0] K_INSERT = 2'd1;
    localparam logic [1:0] K_RESET  = 2'd2;
    localparam logic [1:0] K_UNUSED = 2'd3;

    // Insert status codes.
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_DUP = 2'd1;
    localparam logic [1:0] ST_REJ = 2'd2;

    // Proximity codes.
    localparam logic [1:0] PX_NONE     = 2'd0;
    localparam logic [1:0] PX_SCHEDULE = 2'd1;
    localparam logic [1:0] PX_ANNOUNCE = 2'd2;
    localparam logic [1:0] PX_ALERT    = 2'd3;

    localparam logic [31:0] DAY_SECONDS   = 32'd86400;
    localparam logic [31:0] ALERT_SECONDS = 32'd10;
    localparam logic [63:0] STEP_SLACK    = 64'd3;
    localparam logic [63:0] ALL_ONES      = {64{1'b1}};

    localparam int IN_DATA_W  = 168;
    localparam int OUT_DATA_W = 216;

    typedef struct packed {
        logic [63:0]        time_s;
        logic [21:0]        lead;
        logic signed [15:0] offset;
        logic               dyn;
    } t_entry;

    typedef struct packed {
        logic [1:0]         kind;
        logic [63:0]        query_time;
        logic [63:0]        entry_time;
        logic [21:0]        entry_lead;
        logic signed [15:0] entry_tai;
        logic               entry_dynamic;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic               fired;
        logic signed [15:0] warped;
        logic signed [15:0] era_offset;
        logic signed [15:0] offset_step;
        logic [63:0]        era_start;
        logic [63:0]        next_transition;
        logic [31:0]        due_distance;
        logic               next_dynamic;
        logic [1:0]         proximity;
    } t_res;

endpackage

@@ hdl/leap_second_table_scheduler_top.sv @@
// Top level of the leap-second table scheduler: stream ports, config register,
// result register. Instantiates lsts_ctrl; uses lsts_pkg.
//
// Usage:
//   Items enter on the s_axis channel (kind in tuser, payload in tdata) and
//   one result beat per item leaves on the m_axis channel. The cfg channel
//   writes electric_mode and is always ready; it is to be written only
//   while idle, which the block itself does not enforce. Each item is worked
//   through by a sequencer around one shared 64-bit adder/comparator; the
//   block takes a new item only after the previous one has finished its
//   steps. A query that leaves the cached era walks the table, with one
//   registered read and one compare per entry visited.
//   The result sits in an output register, so the next item is taken while
//   a finished result waits; if the receiver stalls with one result held and
//   another finished, the sequencer holds until the register frees up.
//   Synchronous reset empties the table, zeroes the offsets, sets the cached
//   era times to all ones, clears electric_mode and drops tvalid.
module leap_second_table_scheduler_top #(
    parameter int TABLE_DEPTH = lsts_pkg::TABLE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // query_time[63:0], entry_time[127:64], entry_lead[149:128],
    // entry_tai[165:150], entry_dynamic[166], zero[167]
    input  logic [lsts_pkg::IN_DATA_W-1:0] i_s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // status[1:0], fired[2], warped[18:3], era_offset[34:19], offset_step[50:35],
    // era_start[114:51], next_transition[178:115], due_distance[210:179],
    // next_dynamic[211], proximity[213:212], zero[215:214]
    output logic [lsts_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_data
);
    import lsts_pkg::*;

    logic   r_electric;
    logic   r_out_valid;
    t_res   r_out;
    t_req   req;
    t_res   res;
    logic   res_valid, res_ready, req_ready;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_electric <= 1'b0;
        end else if (i_cfg_valid) begin
            r_electric <= i_cfg_data;
        end
    end
    assign o_cfg_ready = 1'b1;

    // Unpack the input beat.
    assign req.kind          = i_s_axis_tuser;
    assign req.query_time    = i_s_axis_tdata[63:0];
    assign req.entry_time    = i_s_axis_tdata[127:64];
    assign req.entry_lead    = i_s_axis_tdata[149:128];
    assign req.entry_tai     = i_s_axis_tdata[165:150];
    assign req.entry_dynamic = i_s_axis_tdata[166];

    lsts_ctrl #(.DEPTH(TABLE_DEPTH)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_electric  (r_electric),
        .i_req_valid (i_s_axis_tvalid),
        .o_req_ready (req_ready),
        .i_req       (req),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );
    assign o_s_axis_tready = req_ready;

    // Output register decouples the receiver from the sequencer.
    assign res_ready = !r_out_valid || i_m_axis_tready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    // Pack the result beat.
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out.proximity, r_out.next_dynamic,
                              r_out.due_distance, r_out.next_transition,
                              r_out.era_start, r_out.offset_step, r_out.era_offset,
                              r_out.warped, r_out.fired, r_out.status};

endmodule

@@ hdl/lsts_table.sv @@
// Newest-first entry store of the leap-second table scheduler.
// A circular memory written at a moving head, with one registered read port; uses lsts_pkg.
module lsts_table #(
    parameter int DEPTH = 10,
    parameter int IW    = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_shift,
    input  lsts_pkg::t_entry i_wr,
    input  logic [IW-1:0]   i_rd_idx,
    output lsts_pkg::t_entry o_rd
);
    import lsts_pkg::*;

    localparam logic [IW:0]   DEPTH_W = (IW+1)'(DEPTH);
    localparam logic [IW-1:0] LAST    = IW'(DEPTH - 1);

    t_entry        mem [DEPTH];
    t_entry        r_rd;
    logic [IW-1:0] r_head, n_head;
    logic [IW:0]   rd_sum, rd_wrap;
    logic [IW-1:0] rd_phys;

    // Insert steps the head back one place, so the evicted oldest slot takes the new entry.
    assign n_head = (r_head == '0) ? LAST : r_head - 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
        end else if (i_shift) begin
            r_head <= n_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            mem[n_head] <= i_wr;
        end
    end

    // Entry age to slot: head plus index, wrapped once at the depth.
    assign rd_sum  = {1'b0, r_head} + {1'b0, i_rd_idx};
    assign rd_wrap = rd_sum - DEPTH_W;
    assign rd_phys = (rd_sum >= DEPTH_W) ? rd_wrap[IW-1:0] : rd_sum[IW-1:0];

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (int'(i_rd_idx) < DEPTH) begin
            r_rd <= mem[rd_phys];
        end
    end

    assign o_rd = r_rd;

endmodule

@@ hdl/lsts_alu.sv @@
// Shared 64-bit add/subtract unit of the leap-second table scheduler.
// Subtraction gives the no-borrow flag used for the sequencer's 64-bit magnitude compares.
module lsts_alu (
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    input  logic        i_sub,
    output logic [63:0] o_sum,
    output logic        o_carry,
    output logic        o_zero
);
    logic [64:0] sum65;

    // With subtract, carry out high means a >= b.
    assign sum65   = {1'b0, i_a} + {1'b0, (i_sub ? ~i_b : i_b)} + {64'd0, i_sub};
    assign o_sum   = sum65[63:0];
    assign o_carry = sum65[64];
    assign o_zero  = (sum65[63:0] == 64'd0);

endmodule

@@ hdl/lsts_ctrl.sv @@
// Sequencer of the leap-second table scheduler: insert, era walk and query steps.
// Drives the shared adder lsts_alu and the store lsts_table; uses lsts_pkg.
module lsts_ctrl #(
    parameter int DEPTH = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_electric,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  lsts_pkg::t_req i_req,
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output lsts_pkg::t_res o_res
);
    import lsts_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_INS_A    = 5'd1;
    localparam logic [4:0] S_INS_B    = 5'd2;
    localparam logic [4:0] S_INS_C    = 5'd3;
    localparam logic [4:0] S_Q_BASE   = 5'd4;
    localparam logic [4:0] S_Q_DUE    = 5'd5;
    localparam logic [4:0] S_Q_LIM    = 5'd6;
    localparam logic [4:0] S_Q_LIMCMP = 5'd7;
    localparam logic [4:0] S_Q_WARP   = 5'd8;
    localparam logic [4:0] S_Q_NEXT   = 5'd9;
    localparam logic [4:0] S_W_ADR    = 5'd10;
    localparam logic [4:0] S_W_CMP    = 5'd11;
    localparam logic [4:0] S_W_DUE    = 5'd12;
    localparam logic [4:0] S_W_SCH    = 5'd13;
    localparam logic [4:0] S_Q_FIRE   = 5'd14;
    localparam logic [4:0] S_O_SCH    = 5'd15;
    localparam logic [4:0] S_O_DIST   = 5'd16;
    localparam logic [4:0] S_DONE     = 5'd17;

    logic [4:0]         r_state, n_state;
    logic [1:0]         r_kind;
    logic [63:0]        r_ts, r_t, r_et, r_last, r_lim;
    logic [21:0]        r_lead_in, r_lead;
    logic signed [15:0] r_tai, r_base, r_cur, r_up_off, r_warp;
    logic               r_dyn_in, r_up_dyn, r_step, r_fired, r_sch;
    logic [CW-1:0]      r_i, r_count;
    logic [63:0]        r_era, r_trans, r_due, r_sched;
    logic [1:0]         r_status;
    logic [31:0]        r_dist;

    logic [63:0]  alu_a, alu_b, alu_sum;
    logic         alu_sub, alu_carry, alu_zero;
    logic [IW-1:0] rd_idx;
    t_entry       rd, wr;
    logic         tbl_shift;
    logic signed [16:0] diff17;
    logic signed [15:0] first_base;
    logic [1:0]   prox;

    lsts_alu u_alu (
        .i_a     (alu_a),
        .i_b     (alu_b),
        .i_sub   (alu_sub),
        .o_sum   (alu_sum),
        .o_carry (alu_carry),
        .o_zero  (alu_zero)
    );

    assign rd_idx    = (r_state == S_INS_B) ? IW'(DEPTH - 1) : r_i[IW-1:0];
    assign tbl_shift = (r_state == S_INS_C);
    assign wr        = '{time_s: r_et, lead: r_lead_in, offset: r_tai, dyn: r_dyn_in};

    lsts_table #(.DEPTH(DEPTH), .IW(IW)) u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_shift  (tbl_shift),
        .i_wr     (wr),
        .i_rd_idx (rd_idx),
        .o_rd     (rd)
    );

    // Offset step between the upcoming and the current era, one bit wider.
    assign diff17     = {r_up_off[15], r_up_off} - {r_cur[15], r_cur};
    assign first_base = r_tai[15] ? (r_tai + 16'sd1) : (r_tai - 16'sd1);

    // Operand selection for the shared adder.
    always_comb begin
        alu_a   = r_ts;
        alu_b   = r_era;
        alu_sub = 1'b1;
        unique case (r_state)
            S_INS_B:    begin alu_a = r_et;    alu_b = rd.time_s; end
            S_Q_DUE:    begin alu_b = r_due; end
            S_Q_LIM:    begin alu_a = r_due;   alu_b = STEP_SLACK; alu_sub = 1'b0; end
            S_Q_LIMCMP: begin alu_b = r_lim; end
            S_Q_WARP:   begin alu_a = r_trans; alu_b = r_due; end
            S_Q_NEXT:   begin alu_b = {{48{r_warp[15]}}, r_warp}; alu_sub = 1'b0; end
            S_W_CMP:    begin alu_a = r_t;     alu_b = rd.time_s; end
            S_W_DUE:    begin
                alu_a   = r_trans;
                alu_b   = {{47{diff17[16]}}, diff17};
                alu_sub = 1'b0;
            end
            S_W_SCH:    begin alu_a = r_trans; alu_b = {42'd0, r_lead}; end
            S_Q_FIRE:   begin alu_a = r_era;   alu_b = r_last; end
            S_O_SCH:    begin alu_b = r_sched; end
            S_O_DIST:   begin alu_a = r_due;   alu_b = r_ts; end
            default:    begin end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    case (i_req.kind)
                        K_QUERY:  n_state = S_Q_BASE;
                        K_INSERT: n_state = S_INS_A;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_INS_A: n_state = S_INS_B;
            S_INS_B: begin
                if (r_count != '0 && (!alu_carry || alu_zero)) n_state = S_DONE;
                else n_state = S_INS_C;
            end
            S_INS_C:    n_state = S_DONE;
            S_Q_BASE:   n_state = alu_carry ? S_Q_DUE : S_W_ADR;
            S_Q_DUE:    n_state = alu_carry ? S_Q_LIM : S_O_SCH;
            S_Q_LIM:    n_state = S_Q_LIMCMP;
            S_Q_LIMCMP: n_state = alu_carry ? S_W_ADR : S_Q_WARP;
            S_Q_WARP:   n_state = S_Q_NEXT;
            S_Q_NEXT:   n_state = S_W_ADR;
            S_W_ADR:    n_state = (r_i < r_count) ? S_W_CMP : S_W_DUE;
            S_W_CMP:    n_state = alu_carry ? S_W_DUE : S_W_ADR;
            S_W_DUE: begin
                if (r_i != '0) n_state = S_W_SCH;
                else n_state = r_step ? S_Q_FIRE : S_O_SCH;
            end
            S_W_SCH:  n_state = r_step ? S_Q_FIRE : S_O_SCH;
            S_Q_FIRE: n_state = S_O_SCH;
            S_O_SCH:  n_state = S_O_DIST;
            S_O_DIST: n_state = S_DONE;
            S_DONE:   if (i_res_ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_base   <= '0;
            r_cur    <= '0;
            r_up_off <= '0;
            r_up_dyn <= 1'b0;
            r_era    <= ALL_ONES;
            r_trans  <= ALL_ONES;
            r_due    <= ALL_ONES;
            r_sched  <= ALL_ONES;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (i_req_valid && i_req.kind == K_RESET) begin
                        r_era   <= ALL_ONES;
                        r_trans <= ALL_ONES;
                        r_due   <= ALL_ONES;
                        r_sched <= ALL_ONES;
                    end
                end
                S_INS_C: begin
                    if (r_count == '0) begin
                        r_base <= first_base;
                    end else if (r_count >= CW'(DEPTH)) begin
                        r_base <= rd.offset;
                    end
                    if (r_count < CW'(DEPTH)) r_count <= r_count + 1'b1;
                    r_era   <= ALL_ONES;
                    r_trans <= ALL_ONES;
                    r_due   <= ALL_ONES;
                    r_sched <= ALL_ONES;
                end
                S_W_ADR: begin
                    if (r_i >= r_count) begin
                        r_era <= 64'd0;
                        r_cur <= r_base;
                    end
                end
                S_W_CMP: begin
                    if (!alu_carry) begin
                        r_up_off <= rd.offset;
                        r_up_dyn <= rd.dyn;
                        r_trans  <= rd.time_s;
                    end else begin
                        r_era <= rd.time_s;
                        r_cur <= rd.offset;
                    end
                end
                S_W_DUE: begin
                    if (r_i == '0) begin
                        r_trans  <= ALL_ONES;
                        r_due    <= ALL_ONES;
                        r_sched  <= ALL_ONES;
                        r_up_off <= r_cur;
                        r_up_dyn <= 1'b0;
                    end else begin
                        r_due <= i_electric ? r_trans : alu_sum;
                    end
                end
                S_W_SCH: r_sched <= alu_sum;
                default: begin end
            endcase
        end
    end

    // Item payload and working values.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    r_kind    <= i_req.kind;
                    r_ts      <= i_req.query_time;
                    r_t       <= i_req.query_time;
                    r_et      <= i_req.entry_time;
                    r_lead_in <= i_req.entry_lead;
                    r_tai     <= i_req.entry_tai;
                    r_dyn_in  <= i_req.entry_dynamic;
                    r_i       <= '0;
                    r_step    <= 1'b0;
                    r_fired   <= 1'b0;
                    r_warp    <= '0;
                    r_sch     <= 1'b0;
                    r_dist    <= '0;
                    r_status  <= ST_OK;
                end
            end
            S_INS_B: begin
                if (r_count != '0 && !alu_carry) r_status <= ST_REJ;
                else if (r_count != '0 && alu_zero)
                    r_status <= (r_tai != rd.offset) ? ST_REJ : ST_DUP;
            end
            S_Q_LIM:  r_lim <= alu_sum;
            S_Q_WARP: begin
                r_warp <= alu_sum[15:0];
                r_last <= r_trans;
            end
            S_Q_NEXT: begin
                r_t    <= alu_sum;
                r_step <= 1'b1;
            end
            S_W_CMP: begin
                if (!alu_carry) begin
                    r_i    <= r_i + 1'b1;
                    r_lead <= rd.lead;
                end
            end
            S_Q_FIRE: begin
                if (alu_zero) begin
                    r_fired <= 1'b1;
                    r_ts    <= r_t;
                end else begin
                    r_warp <= '0;
                end
            end
            S_O_SCH:  r_sch  <= alu_carry;
            S_O_DIST: r_dist <= alu_sum[31:0];
            default: begin end
        endcase
    end

    // Proximity from the due distance; zero distance lies outside both windows.
    always_comb begin
        prox = PX_NONE;
        if (r_sch) begin
            prox = PX_SCHEDULE;
            if (r_dist != 32'd0 && r_dist <= DAY_SECONDS) prox = PX_ANNOUNCE;
            if (r_dist != 32'd0 && r_dist <= ALERT_SECONDS) prox = PX_ALERT;
        end
    end

    // Result beat; non-query items carry only the status.
    always_comb begin
        o_res = '0;
        o_res.status = (r_kind == K_INSERT) ? r_status : ST_OK;
        if (r_kind == K_QUERY) begin
            o_res.fired           = r_fired;
            o_res.warped          = r_warp;
            o_res.era_offset      = r_cur;
            o_res.era_start       = r_era;
            o_res.next_transition = r_trans;
            o_res.proximity       = prox;
            if (r_sch) begin
                o_res.offset_step  = r_up_off - r_cur;
                o_res.due_distance = r_dist;
                o_res.next_dynamic = r_up_dyn;
            end
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond table depth");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_W_ADR || r_state == S_W_CMP) |-> r_i <= r_count)
        else $error("era walk ran past the filled entries");

    a_full_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS_C && r_count == CW'(DEPTH)) |=> r_count == CW'(DEPTH))
        else $error("eviction changed the entry count");

    a_fire_era: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_O_SCH && r_fired) |-> r_era == r_last)
        else $error("firing reported without entering the transition era");
`endif

endmodule
